/* hw/rtl/sce_pkg.sv */
// Shared types and constants for the shift chain output expander.
// No dependencies; used by sce_ctrl, sce_dpath and shift_chain_output_expander.
package sce_pkg;

    localparam int IMG_W       = 64;  // output image width
    localparam int PIN_W       = 6;   // image bit index width
    localparam int CHIP_SHIFT  = 3;   // log2 of bits per chip
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 4;
    localparam int CNT_CFG_W   = 4;

    localparam logic [CNT_CFG_W-1:0] CHIP_COUNT_RST = 4'd8;

    // request codes
    localparam logic [1:0] REQ_PIN   = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // pin actions
    localparam logic [1:0] ACT_OFF    = 2'd0;
    localparam logic [1:0] ACT_ON     = 2'd1;
    localparam logic [1:0] ACT_TOGGLE = 2'd2;
    localparam logic [1:0] ACT_KEEP   = 2'd3;

    // result kinds
    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHIP_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LSB_FIRST  = 1'd1;

    typedef enum logic {
        ST_IDLE,
        ST_SEND
    } t_state;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [PIN_W-1:0] pin;
        logic [1:0]       action;
    } t_in_word;

    typedef struct packed {
        logic             result_kind;
        logic             serial_bit;
        logic [PIN_W-1:0] bit_position;
        logic             last_of_run;
        logic             pin_state;
    } t_out_word;

    // controller -> datapath
    typedef struct packed {
        logic update;   // apply pin action or clear to the image
        logic read;     // emit pin read answer
        logic cnt_clr;  // restart frame bit counter
        logic shift;    // emit next frame bit
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic last_bit; // counter is at the final frame bit
    } t_stat;

endpackage

/* hw/rtl/sce_ctrl.sv */
// Control state machine for the shift chain output expander.
// Depends on sce_pkg; drives sce_dpath through t_cmd and reads t_stat.
module sce_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [1:0]      i_req_type,
    input  sce_pkg::t_stat  i_stat,
    output sce_pkg::t_cmd   o_cmd,
    output logic            o_busy
);

    sce_pkg::t_state r_state;
    sce_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sce_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            sce_pkg::ST_IDLE: begin
                if (i_start) begin
                    case (i_req_type)
                        sce_pkg::REQ_PIN, sce_pkg::REQ_CLEAR: begin
                            o_cmd.update  = 1'b1;
                            o_cmd.cnt_clr = 1'b1;
                            n_state       = sce_pkg::ST_SEND;
                        end
                        sce_pkg::REQ_READ: begin
                            o_cmd.read = 1'b1;
                        end
                        default: begin
                            // unused code: dropped
                        end
                    endcase
                end
            end
            sce_pkg::ST_SEND: begin
                o_cmd.shift = 1'b1;
                if (i_stat.last_bit) begin
                    n_state = sce_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sce_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != sce_pkg::ST_IDLE);

endmodule

/* hw/rtl/sce_dpath.sv */
// Datapath: output image, config registers, frame bit counter, output word register.
// Depends on sce_pkg; commanded by sce_ctrl.
module sce_dpath #(
    parameter int MAX_CHIPS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sce_pkg::t_cmd                       i_cmd,
    output sce_pkg::t_stat                      o_stat,
    input  sce_pkg::t_in_word                   i_word,
    input  logic                                i_cfg_we,
    input  logic [sce_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [sce_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output logic                                o_strobe,
    output sce_pkg::t_out_word                  o_word
);

    localparam int CW = $clog2(MAX_CHIPS << sce_pkg::CHIP_SHIFT);
    localparam logic [sce_pkg::CNT_CFG_W-1:0] MAX_N = sce_pkg::CNT_CFG_W'(MAX_CHIPS);

    logic [sce_pkg::IMG_W-1:0]     r_image;
    logic [sce_pkg::CNT_CFG_W-1:0] r_chip_count;
    logic                          r_lsb_first;
    logic [CW-1:0]                 r_cnt;
    logic                          r_strobe;
    sce_pkg::t_out_word            r_word;

    logic [sce_pkg::IMG_W-1:0]     pin_mask;
    logic [sce_pkg::CNT_CFG_W-1:0] chips;
    logic [CW-1:0]                 last_k;
    logic [CW-1:0]                 pos;
    logic [sce_pkg::PIN_W-1:0]     pos_ext;

    assign pin_mask = sce_pkg::IMG_W'(1) << i_word.pin;

    // clamp chain length to 1..MAX_CHIPS
    always_comb begin
        chips = r_chip_count;
        if (r_chip_count == '0) begin
            chips = sce_pkg::CNT_CFG_W'(1);
        end else if (r_chip_count > MAX_N) begin
            chips = MAX_N;
        end
    end

    assign last_k  = CW'(((sce_pkg::CNT_CFG_W + sce_pkg::CHIP_SHIFT)'(chips)
                         << sce_pkg::CHIP_SHIFT) - 1'b1);
    assign pos     = r_lsb_first ? r_cnt : (last_k - r_cnt);
    assign pos_ext = sce_pkg::PIN_W'(pos);
    assign o_stat.last_bit = (r_cnt == last_k);

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chip_count <= sce_pkg::CHIP_COUNT_RST;
            r_lsb_first  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sce_pkg::CFG_CHIP_COUNT: r_chip_count <= i_cfg_data;
                sce_pkg::CFG_LSB_FIRST:  r_lsb_first  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // output image
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image <= '0;
        end else if (i_cmd.update) begin
            if (i_word.req_type == sce_pkg::REQ_CLEAR) begin
                r_image <= '0;
            end else begin
                case (i_word.action)
                    sce_pkg::ACT_OFF:    r_image <= r_image & ~pin_mask;
                    sce_pkg::ACT_ON:     r_image <= r_image | pin_mask;
                    sce_pkg::ACT_TOGGLE: r_image <= r_image ^ pin_mask;
                    default:             r_image <= r_image;
                endcase
            end
        end
    end

    // frame bit counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_clr) begin
            r_cnt <= '0;
        end else if (i_cmd.shift) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.shift | i_cmd.read;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_word.result_kind  <= sce_pkg::KIND_READ;
            r_word.serial_bit   <= 1'b0;
            r_word.bit_position <= i_word.pin;
            r_word.last_of_run  <= 1'b1;
            r_word.pin_state    <= r_image[i_word.pin];
        end else if (i_cmd.shift) begin
            r_word.result_kind  <= sce_pkg::KIND_FRAME;
            r_word.serial_bit   <= r_image[pos_ext];
            r_word.bit_position <= pos_ext;
            r_word.last_of_run  <= (r_cnt == last_k);
            r_word.pin_state    <= 1'b0;
        end
    end

    assign o_strobe = r_strobe;
    assign o_word   = r_word;

endmodule

/* hw/rtl/shift_chain_output_expander.sv */
// Shift chain output expander: 64-bit output image streamed as a serial frame.
// Pin/clear: taken when idle, then chips*8 frame words from the bit counter, one per cycle
// (chips: chip_count clamped to 1..MAX_CHIPS); first word via r_state and r_word. Busy
// holds until the last word shows; no request is taken while busy. Read: answer word is
// registered in the cycle after start; next request can follow at once. Sync active-low
// reset clears image, sets chip_count=8, lsb_first=0, emits nothing. Receiver cannot stall.
module shift_chain_output_expander #(
    parameter int MAX_CHIPS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request channel
    input  logic                           i_start,
    input  sce_pkg::t_in_word              i_word,
    output logic                           o_busy,
    // config write port
    input  logic                           i_cfg_we,
    input  logic [sce_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sce_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // result channel: one word per strobe cycle
    output logic                           o_strobe,
    output sce_pkg::t_out_word             o_word
);

    sce_pkg::t_cmd  cmd;
    sce_pkg::t_stat stat;

    // controller: idle/send sequencing, issues update, read and shift commands
    sce_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .i_req_type (i_word.req_type),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_busy     (o_busy)
    );

    // datapath: image, config, bit counter and registered output word
    sce_dpath #(
        .MAX_CHIPS (MAX_CHIPS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_word     (i_word),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_strobe   (o_strobe),
        .o_word     (o_word)
    );

`ifndef SYNTH
    // a read answer is always a one-word run
    a_read_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_word.result_kind == sce_pkg::KIND_READ) |-> o_word.last_of_run)
        else $error("read answer without last_of_run");

    // frame words: busy stays high exactly until the last word is shown
    a_frame_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_word.result_kind == sce_pkg::KIND_FRAME)
            |-> (o_busy != o_word.last_of_run))
        else $error("frame last_of_run out of step with busy");

    // leaving the send phase always shows the final frame word
    a_end_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(o_busy) && $past(i_rst_n)) |-> (o_strobe && o_word.last_of_run))
        else $error("frame ended without last word");
`endif

endmodule

/* test/shift_chain_output_expander_tb.sv */
// Self-checking testbench for shift_chain_output_expander: directed and random requests.
// Depends on sce_pkg and the shift_chain_output_expander RTL; nothing else.
`timescale 1ns / 1ps

module shift_chain_output_expander_tb;

    localparam int MAX_CHIPS  = 8;
    localparam int IDLE_TAIL  = 6;    // cycles after the last word before touching config
    localparam int PHASES     = 11;
    localparam int PHASE_REQS = 40;
    localparam int MAX_REPORTS = 200; // cap on printed mismatches
    localparam int IN_W       = $bits(sce_pkg::t_in_word);

    // request code with no function
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // Tracks the output image and config as the block should see them, and holds
    // the words still due on the result port, oldest first.
    class frame_tracker;
        logic [sce_pkg::IMG_W-1:0]     image;
        logic [sce_pkg::CNT_CFG_W-1:0] chip_cnt;
        logic                          lsb_first;
        sce_pkg::t_out_word            due_words[$];
        int                            errors;

        function new();
            image     = '0;
            chip_cnt  = sce_pkg::CHIP_COUNT_RST;
            lsb_first = 1'b0;
            errors    = 0;
        endfunction

        function void set_reg(logic [sce_pkg::CFG_IDX_W-1:0] idx,
                              logic [sce_pkg::CFG_DATA_W-1:0] data);
            if (idx == sce_pkg::CFG_CHIP_COUNT)
                chip_cnt = data;
            else if (idx == sce_pkg::CFG_LSB_FIRST)
                lsb_first = data[0];
        endfunction

        // chips actually in the frame: zero acts as one, above the max as the max
        function int chips();
            int n;
            n = int'(chip_cnt);
            if (n < 1)
                n = 1;
            if (n > MAX_CHIPS)
                n = MAX_CHIPS;
            return n;
        endfunction

        function int pending();
            return due_words.size();
        endfunction

        function void queue_frame();
            int                 total;
            int                 pos;
            sce_pkg::t_out_word w;
            total = chips() * 8;
            for (int k = 0; k < total; k++) begin
                pos            = lsb_first ? k : (total - 1 - k);
                w.result_kind  = sce_pkg::KIND_FRAME;
                w.serial_bit   = image[pos];
                w.bit_position = sce_pkg::PIN_W'(pos);
                w.last_of_run  = (k == total - 1);
                w.pin_state    = 1'b0;
                due_words.push_back(w);
            end
        endfunction

        // one accepted request word
        function void take_request(sce_pkg::t_in_word req);
            sce_pkg::t_out_word w;
            case (req.req_type)
                sce_pkg::REQ_PIN: begin
                    case (req.action)
                        sce_pkg::ACT_OFF:    image[req.pin] = 1'b0;
                        sce_pkg::ACT_ON:     image[req.pin] = 1'b1;
                        sce_pkg::ACT_TOGGLE: image[req.pin] = ~image[req.pin];
                        default:    ; // keep: frame still goes out
                    endcase
                    queue_frame();
                end
                sce_pkg::REQ_READ: begin
                    w.result_kind  = sce_pkg::KIND_READ;
                    w.serial_bit   = 1'b0;
                    w.bit_position = req.pin;
                    w.last_of_run  = 1'b1;
                    w.pin_state    = image[req.pin];
                    due_words.push_back(w);
                end
                sce_pkg::REQ_CLEAR: begin
                    image = '0;
                    queue_frame();
                end
                default: ; // unused request code, ignored
            endcase
        endfunction

        function void field_diff(string name, int exp_v, int got_v);
            if (exp_v != got_v) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $error("%s: expected %0d, actual %0d", name, exp_v, got_v);
            end
        endfunction

        function void check_word(sce_pkg::t_out_word got);
            sce_pkg::t_out_word exp_w;
            if (due_words.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $error("unexpected result word %h", got);
                return;
            end
            exp_w = due_words.pop_front();
            field_diff("result_kind", int'(exp_w.result_kind), int'(got.result_kind));
            field_diff("serial_bit", int'(exp_w.serial_bit), int'(got.serial_bit));
            field_diff("bit_position", int'(exp_w.bit_position), int'(got.bit_position));
            field_diff("last_of_run", int'(exp_w.last_of_run), int'(got.last_of_run));
            field_diff("pin_state", int'(exp_w.pin_state), int'(got.pin_state));
        endfunction
    endclass

    logic                           i_clk      = 1'b0;
    logic                           i_rst_n    = 1'b0;
    logic                           i_start    = 1'b0;
    sce_pkg::t_in_word              i_word     = '0;
    logic                           i_cfg_we   = 1'b0;
    logic [sce_pkg::CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [sce_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                           o_busy;
    logic                           o_strobe;
    sce_pkg::t_out_word             o_word;

    frame_tracker trk = new();

    shift_chain_output_expander #(
        .MAX_CHIPS(MAX_CHIPS)
    ) i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_start),
        .i_word    (i_word),
        .o_busy    (o_busy),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .o_strobe  (o_strobe),
        .o_word    (o_word)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Monitor: everything is sampled at the edge, before any driver update lands.
    // Results are checked before the request of the same edge is noted; a request
    // never produces a word on the edge it is accepted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe)
                trk.check_word(o_word);
            if (i_start && !o_busy)
                trk.take_request(i_word);
        end
    end

    // Hold start high with the word until an edge sees busy low. Start is left
    // high on return so back-to-back words need no lowering.
    task automatic send_word(input sce_pkg::t_in_word w);
        i_start <= 1'b1;
        i_word  <= w;
        do @(posedge i_clk); while (o_busy);
    endtask

    // Sender gap; junk on the word bus so the block must honor start.
    task automatic idle_cycles(input int n);
        logic [IN_W-1:0] junk;
        i_start <= 1'b0;
        repeat (n) begin
            junk   = IN_W'($urandom);
            i_word <= junk;
            @(posedge i_clk);
        end
    endtask

    // Stop sending until every due word has come, plus a tail for requests
    // that produce nothing.
    task automatic wait_drained();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (trk.pending() != 0)
            @(posedge i_clk);
        repeat (IDLE_TAIL) @(posedge i_clk);
    endtask

    // Both registers, back to back. Upper data bits of lsb_first are don't-care noise.
    task automatic write_config(input logic [sce_pkg::CFG_DATA_W-1:0] cc, input logic lsb);
        logic [sce_pkg::CFG_DATA_W-1:0] lsb_data;
        lsb_data    = sce_pkg::CFG_DATA_W'($urandom);
        lsb_data[0] = lsb;
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= sce_pkg::CFG_CHIP_COUNT;
        i_cfg_data <= cc;
        @(posedge i_clk);
        trk.set_reg(sce_pkg::CFG_CHIP_COUNT, cc);
        i_cfg_idx  <= sce_pkg::CFG_LSB_FIRST;
        i_cfg_data <= lsb_data;
        @(posedge i_clk);
        trk.set_reg(sce_pkg::CFG_LSB_FIRST, lsb_data);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic sce_pkg::t_in_word make_word(logic [1:0] req, int pin,
                                                     logic [1:0] act);
        sce_pkg::t_in_word w;
        w.req_type = req;
        w.pin      = sce_pkg::PIN_W'(pin);
        w.action   = act;
        return w;
    endfunction

    // Mostly pin writes and reads inside the chain, some clears, a few unused codes.
    function automatic sce_pkg::t_in_word random_word();
        sce_pkg::t_in_word w;
        int                r;
        r = $urandom_range(0, 99);
        if (r < 47)
            w.req_type = sce_pkg::REQ_PIN;
        else if (r < 87)
            w.req_type = sce_pkg::REQ_READ;
        else if (r < 95)
            w.req_type = sce_pkg::REQ_CLEAR;
        else
            w.req_type = REQ_UNUSED;
        if ($urandom_range(0, 3) != 0)
            w.pin = sce_pkg::PIN_W'($urandom_range(0, trk.chips() * 8 - 1));
        else
            w.pin = sce_pkg::PIN_W'($urandom_range(0, sce_pkg::IMG_W - 1));
        w.action = 2'($urandom_range(0, 3));
        return w;
    endfunction

    initial begin
        int accepted;
        int burst;
        int r;
        logic [sce_pkg::CFG_DATA_W-1:0] cc;
        sce_pkg::t_in_word w;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, reset config: eight chips, MSB first.
        send_word(make_word(sce_pkg::REQ_READ, 0, sce_pkg::ACT_OFF));   // image reset to zero
        send_word(make_word(sce_pkg::REQ_READ, 63, sce_pkg::ACT_ON));
        send_word(make_word(sce_pkg::REQ_PIN, 0, sce_pkg::ACT_ON));
        send_word(make_word(sce_pkg::REQ_PIN, 63, sce_pkg::ACT_ON));
        send_word(make_word(sce_pkg::REQ_READ, 63, sce_pkg::ACT_KEEP));
        send_word(make_word(sce_pkg::REQ_PIN, 63, sce_pkg::ACT_TOGGLE));
        send_word(make_word(sce_pkg::REQ_PIN, 21, sce_pkg::ACT_TOGGLE));
        send_word(make_word(sce_pkg::REQ_PIN, 21, sce_pkg::ACT_KEEP)); // frame still sent
        send_word(make_word(sce_pkg::REQ_PIN, 0, sce_pkg::ACT_OFF));
        send_word(make_word(sce_pkg::REQ_READ, 21, sce_pkg::ACT_TOGGLE));
        send_word(make_word(REQ_UNUSED, 42, sce_pkg::ACT_ON));         // nothing happens
        send_word(make_word(sce_pkg::REQ_READ, 42, sce_pkg::ACT_OFF));
        send_word(make_word(sce_pkg::REQ_CLEAR, 37, sce_pkg::ACT_TOGGLE));
        send_word(make_word(sce_pkg::REQ_READ, 21, sce_pkg::ACT_OFF));
        wait_drained();

        // Chip count zero acts as one chip; LSB first. Pin past the chain still sticks.
        write_config(4'd0, 1'b1);
        send_word(make_word(sce_pkg::REQ_PIN, 7, sce_pkg::ACT_ON));
        send_word(make_word(sce_pkg::REQ_PIN, 50, sce_pkg::ACT_ON));
        send_word(make_word(sce_pkg::REQ_READ, 50, sce_pkg::ACT_KEEP));
        send_word(make_word(sce_pkg::REQ_PIN, 1, sce_pkg::ACT_KEEP));
        wait_drained();

        // Chip count above the max acts as eight chips.
        write_config(4'd15, 1'b0);
        send_word(make_word(sce_pkg::REQ_PIN, 56, sce_pkg::ACT_TOGGLE));
        send_word(make_word(sce_pkg::REQ_READ, 56, sce_pkg::ACT_ON));
        send_word(make_word(sce_pkg::REQ_CLEAR, 0, sce_pkg::ACT_OFF));
        wait_drained();

        // Random phases: extreme settings first, then random, mostly short chains.
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: write_config(4'd1, 1'b0);
                1: write_config(4'd8, 1'b1);
                2: write_config(4'd0, 1'b0);
                3: write_config(4'd15, 1'b1);
                4: write_config(4'd9, 1'b0);
                default: begin
                    if ($urandom_range(0, 9) < 7)
                        cc = 4'($urandom_range(0, 3));
                    else
                        cc = 4'($urandom_range(4, 15));
                    write_config(cc, 1'($urandom_range(0, 1)));
                end
            endcase
            accepted = 0;
            while (accepted < PHASE_REQS) begin
                burst = $urandom_range(1, 10);
                for (int b = 0; b < burst; b++) begin
                    w = random_word();
                    send_word(w);
                    if (w.req_type != REQ_UNUSED)
                        accepted++;
                end
                r = $urandom_range(0, 99);
                if (r < 4)
                    wait_drained();                       // full pause until all words are in
                else if (r < 22)
                    ;                                     // no gap: next burst follows at once
                else if (r < 35)
                    idle_cycles($urandom_range(5, 70));   // long gap, lands mid-frame
                else
                    idle_cycles($urandom_range(1, 4));
            end
            wait_drained();
        end

        if (trk.errors == 0 && trk.pending() == 0)
            $display("shift_chain_output_expander_tb OK");
        else
            $display("shift_chain_output_expander_tb NOT OK");
        $finish;
    end

    // Watchdog, several times the slowest correct run.
    initial begin
        #5_000_000;
        $display("shift_chain_output_expander_tb NOT OK");
        $finish;
    end

endmodule
